/* rtl/mrir_pkg.sv */
`default_nettype none

package mrir_pkg;

    localparam int FRAME_BYTES = 8;

    // frame byte positions
    localparam logic [2:0] POS_ADDR    = 3'd0;
    localparam logic [2:0] POS_REG_LO  = 3'd3;
    localparam logic [2:0] POS_CRC_LO  = 3'(FRAME_BYTES - 2);
    localparam logic [2:0] POS_CRC_HI  = 3'(FRAME_BYTES - 1);

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0] REPLY_BYTE_CNT  = 8'h02;
    localparam logic [7:0] CFG_RESET       = 8'h01;

    // result status codes
    localparam logic [2:0] ST_REPLY  = 3'd0;
    localparam logic [2:0] ST_CRC    = 3'd1;
    localparam logic [2:0] ST_REG    = 3'd2;
    localparam logic [2:0] ST_ADDR   = 3'd3;
    localparam logic [2:0] ST_SENSOR = 3'd4;
    localparam logic [2:0] ST_LINE   = 3'd5;

    // configuration register indexes
    localparam logic REG_SLAVE_ADDR = 1'b0;
    localparam logic REG_SERVED     = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [15:0] sensor;
    } mrir_job_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/mrir_apb.sv */
`default_nettype none

module mrir_apb
    import mrir_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [7:0]       station_addr,
    output logic [7:0]       served_register
);

    logic [7:0] station_addr_reg;
    logic [7:0] served_register_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_addr_reg    <= CFG_RESET;
            served_register_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_SLAVE_ADDR)
                station_addr_reg <= pwdata[7:0];
            else
                served_register_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_SLAVE_ADDR)
            prdata = {24'h000000, station_addr_reg};
        else
            prdata = {24'h000000, served_register_reg};
    end

    assign station_addr    = station_addr_reg;
    assign served_register = served_register_reg;

endmodule

`default_nettype wire

/* rtl/mrir_frame.sv */
`default_nettype none

module mrir_frame
    import mrir_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic [7:0]         rx_byte,
    input  wire logic signed [15:0] sensor_reading,
    input  wire logic               sensor_valid,
    input  wire logic [7:0]         station_addr,
    input  wire logic [7:0]         served_register,
    input  wire logic               job_take,
    output mrir_job_t               job
);

    logic        hold_valid_reg;
    logic        hold_valid_next;
    logic        hold_kind_reg;
    logic [7:0]  hold_byte_reg;
    logic [15:0] hold_sensor_reg;
    logic        hold_sensor_ok_reg;

    logic [2:0]  byte_count_reg,  byte_count_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic        addr_match_reg,  addr_match_next;
    logic [7:0]  register_low_reg, register_low_next;
    logic [7:0]  crc_low_reg,     crc_low_next;

    logic        accept;
    logic        advance;
    logic        has_result;
    logic [2:0]  verdict;

    assign has_result = hold_kind_reg | (byte_count_reg == POS_CRC_HI);
    assign advance    = hold_valid_reg & (~has_result | job_take);
    assign in_stall   = hold_valid_reg & ~advance;
    assign accept     = in_valid & ~in_stall;

    assign hold_valid_next = accept | (hold_valid_reg & ~advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_kind_reg      <= kind;
            hold_byte_reg      <= rx_byte;
            hold_sensor_reg    <= sensor_reading;
            hold_sensor_ok_reg <= sensor_valid;
        end
    end

    // judge the frame on its closing byte, or flag a line error
    always_comb
    begin
        if (hold_kind_reg)
            verdict = ST_LINE;
        else if (!addr_match_reg)
            verdict = ST_ADDR;
        else if (crc_low_reg != running_crc_reg[7:0] || hold_byte_reg != running_crc_reg[15:8])
            verdict = ST_CRC;
        else if (register_low_reg != served_register)
            verdict = ST_REG;
        else if (!hold_sensor_ok_reg)
            verdict = ST_SENSOR;
        else
            verdict = ST_REPLY;
    end

    assign job.valid  = hold_valid_reg & has_result;
    assign job.status = verdict;
    assign job.sensor = hold_sensor_reg;

    always_comb
    begin
        byte_count_next   = byte_count_reg;
        running_crc_next  = running_crc_reg;
        addr_match_next   = addr_match_reg;
        register_low_next = register_low_reg;
        crc_low_next      = crc_low_reg;
        if (advance)
        begin
            if (has_result)
            begin
                // line error or judged frame: start afresh
                byte_count_next   = 3'd0;
                running_crc_next  = CRC_INIT;
                addr_match_next   = 1'b0;
                register_low_next = 8'h00;
                crc_low_next      = 8'h00;
            end
            else if (byte_count_reg == POS_CRC_LO)
            begin
                crc_low_next    = hold_byte_reg;
                byte_count_next = byte_count_reg + 3'd1;
            end
            else
            begin
                if (byte_count_reg == POS_ADDR)
                    addr_match_next = (hold_byte_reg == station_addr);
                if (byte_count_reg == POS_REG_LO)
                    register_low_next = hold_byte_reg;
                running_crc_next = crc_feed(running_crc_reg, hold_byte_reg);
                byte_count_next  = byte_count_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= 3'd0;
            running_crc_reg  <= CRC_INIT;
            addr_match_reg   <= 1'b0;
            register_low_reg <= 8'h00;
            crc_low_reg      <= 8'h00;
        end
        else
        begin
            byte_count_reg   <= byte_count_next;
            running_crc_reg  <= running_crc_next;
            addr_match_reg   <= addr_match_next;
            register_low_reg <= register_low_next;
            crc_low_reg      <= crc_low_next;
        end
    end

    a_job_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        job.valid |-> hold_valid_reg)
        else $error("result job without a held request");

    a_line_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && hold_kind_reg) |=> (byte_count_reg == 3'd0 && running_crc_reg == CRC_INIT))
        else $error("frame state not cleared after line error");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && !job_take) |-> job.valid)
        else $error("input stalled without a pending result");

endmodule

`default_nettype wire

/* rtl/mrir_tx.sv */
`default_nettype none

module mrir_tx
    import mrir_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire mrir_job_t  job,
    output logic            job_take,
    input  wire logic [7:0] station_addr,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      tx_byte,
    output logic            last,
    output logic [2:0]      status
);

    localparam logic [2:0] IDX_ADDR   = 3'd0;
    localparam logic [2:0] IDX_FUNC   = 3'd1;
    localparam logic [2:0] IDX_COUNT  = 3'd2;
    localparam logic [2:0] IDX_VAL_HI = 3'd3;
    localparam logic [2:0] IDX_VAL_LO = 3'd4;
    localparam logic [2:0] IDX_CRC_LO = 3'd5;
    localparam logic [2:0] IDX_CRC_HI = 3'd6;

    logic        busy_reg;
    logic [2:0]  status_reg;
    logic [15:0] sensor_reg;
    logic [2:0]  idx_reg;
    logic [15:0] crc_reg;
    logic        out_accept;
    logic        is_reply;
    logic [7:0]  cur_byte;

    assign is_reply   = (status_reg == ST_REPLY);
    assign out_valid  = busy_reg;
    assign out_accept = busy_reg & ~out_stall;
    assign last       = ~is_reply | (idx_reg == IDX_CRC_HI);
    assign job_take   = ~busy_reg | (out_accept & last);
    assign status     = status_reg;
    assign tx_byte    = is_reply ? cur_byte : 8'h00;

    always_comb
    begin
        case (idx_reg)
            IDX_ADDR:   cur_byte = station_addr;
            IDX_FUNC:   cur_byte = FUNC_READ_INPUT;
            IDX_COUNT:  cur_byte = REPLY_BYTE_CNT;
            IDX_VAL_HI: cur_byte = sensor_reg[15:8];
            IDX_VAL_LO: cur_byte = sensor_reg[7:0];
            IDX_CRC_LO: cur_byte = crc_reg[7:0];
            IDX_CRC_HI: cur_byte = crc_reg[15:8];
            default:    cur_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= IDX_ADDR;
        end
        else if (job_take)
        begin
            busy_reg <= job.valid;
            idx_reg  <= IDX_ADDR;
        end
        else if (out_accept)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // crc of the reply builds up as its bytes go out
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            status_reg <= job.status;
            sensor_reg <= job.sensor;
            crc_reg    <= CRC_INIT;
        end
        else if (out_accept && idx_reg < IDX_CRC_LO)
        begin
            crc_reg <= crc_feed(crc_reg, cur_byte);
        end
    end

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_REPLY) |-> (last && tx_byte == 8'h00))
        else $error("error result not single");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= IDX_CRC_HI))
        else $error("reply index out of range");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && last && !job.valid) |=> !busy_reg)
        else $error("output still valid after final result");

endmodule

`default_nettype wire

/* rtl/modbus_rtu_input_register_responder.sv */
// An accepted request is registered in the frame hold register, then taken by
// the reply stage. Throughput: one request per cycle while no result is
// pending; a good frame gives seven reply bytes, one per cycle while
// out_stall is low, others one zero byte; another request is held meanwhile.
// Reset: asynchronous, clears the frame state and pending results and sets
// both configuration registers to 1.
`default_nettype none

module modbus_rtu_input_register_responder
    import mrir_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic [7:0]         rx_byte,
    input  wire logic signed [15:0] sensor_reading,
    input  wire logic               sensor_valid,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              tx_byte,
    output logic                    last,
    output logic [2:0]              status
);

    logic [7:0] station_addr;
    logic [7:0] served_register;
    mrir_job_t  job;
    logic       job_take;

    mrir_apb u_apb (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .station_addr    (station_addr),
        .served_register (served_register)
    );

    mrir_frame u_frame (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .rx_byte         (rx_byte),
        .sensor_reading  (sensor_reading),
        .sensor_valid    (sensor_valid),
        .station_addr    (station_addr),
        .served_register (served_register),
        .job_take        (job_take),
        .job             (job)
    );

    mrir_tx u_tx (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (job),
        .job_take      (job_take),
        .station_addr  (station_addr),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tx_byte       (tx_byte),
        .last          (last),
        .status        (status)
    );

endmodule

`default_nettype wire
